### rtl/string_intern_table_macros.svh
// assertion macros for the string intern table
`ifndef STRING_INTERN_TABLE_MACROS_SVH
`define STRING_INTERN_TABLE_MACROS_SVH

// assert that an antecedent implies a consequent in the same cycle
`define SIT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// assert that an antecedent implies a consequent in the next cycle
`define SIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/sit_pkg.sv
// types and constants shared by the string intern table
package sit_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int STORE_BYTES = 4096;

  localparam logic [1:0] OP_INTERN = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] ST_NEW        = 3'd0;
  localparam logic [2:0] ST_FOUND      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_STORE_FULL = 3'd4;
  localparam logic [2:0] ST_NULL       = 3'd5;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_byte;
    logic       key_last;
    logic [7:0] string_id;
  } sit_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  result_id;
    logic [11:0] store_offset;
    logic [11:0] string_length;
    logic [7:0]  entry_total;
    logic [31:0] request_count;
    logic [31:0] dedup_count;
  } sit_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic stage;      // stage key byte, update hash
    logic clear;      // clear table and counters
    logic drop;       // drop staged key
    logic count_req;  // bump request count
    logic count_dup;  // bump dedup count
    logic probe_init; // load probe index from hash or zero
    logic probe_lkp;  // probe start at slot zero
    logic probe_next; // advance probe index
    logic rd_slot;    // read slot memories at probe index
    logic cmp_init;   // start byte compare
    logic cmp_step;   // compare one byte
    logic rd_bytes;   // read both store bytes
    logic commit;     // write slot and terminator
    logic ld_res;     // load result register
    logic [2:0] res_status;
    logic res_slot;   // result carries slot info
  } sit_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic overflow;
    logic slot_empty;
    logic slot_meta_eq;
    logic slot_id_eq;
    logic probe_done;
    logic cmp_done;
    logic cmp_eq;
    logic tbl_cap;
    logic store_fit;
  } sit_stat_t;

endpackage

### rtl/sit_stream_if.sv
// valid ready channel carrying one word
interface sit_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/sit_ctrl.sv
// controller state machine for the string intern table
module sit_ctrl
  import sit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sit_in_t    in_word,
  input  logic       out_busy,
  input  sit_stat_t  stat,
  output sit_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_CMP_RD = 4'd4;
  localparam logic [3:0] S_CMP_CK = 4'd5;
  localparam logic [3:0] S_LK_RD  = 4'd6;
  localparam logic [3:0] S_LK_CHK = 4'd7;
  localparam logic [3:0] S_CMP_WT = 4'd8;
  localparam logic [3:0] S_MISS   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       intern_op;
  logic       intern_op_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      intern_op <= 1'b0;
    end else begin
      state     <= state_next;
      intern_op <= intern_op_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    intern_op_next = intern_op;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !out_busy;
        if (in_valid && !out_busy) begin
          unique case (in_word.opcode)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_LOOKUP: begin
              if (in_word.string_id == 8'd0) begin
                cmd.ld_res     = 1'b1;
                cmd.res_status = ST_NULL;
              end else begin
                cmd.probe_init = 1'b1;
                cmd.probe_lkp  = 1'b1;
                state_next     = S_LK_RD;
              end
            end
            default: begin
              cmd.stage = 1'b1;
              if (in_word.key_last) begin
                intern_op_next = (in_word.opcode == OP_INTERN);
                cmd.count_req  = (in_word.opcode == OP_INTERN);
                state_next     = S_START;
              end
            end
          endcase
        end
      end
      S_START: begin
        if (stat.overflow) begin
          cmd.drop       = 1'b1;
          cmd.ld_res     = 1'b1;
          cmd.res_status = ST_STORE_FULL;
          state_next     = S_IDLE;
        end else begin
          cmd.probe_init = 1'b1;
          state_next     = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_slot = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        if (stat.slot_empty) begin
          state_next = S_MISS;
        end else if (stat.slot_meta_eq) begin
          cmd.cmp_init = 1'b1;
          state_next   = S_CMP_RD;
        end else if (stat.probe_done) begin
          state_next = S_MISS;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_RD;
        end
      end
      S_CMP_RD: begin
        if (stat.cmp_done) begin
          cmd.ld_res     = 1'b1;
          cmd.res_status = ST_FOUND;
          cmd.res_slot   = 1'b1;
          cmd.count_dup  = intern_op;
          cmd.drop       = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_bytes = 1'b1;
          state_next   = S_CMP_WT;
        end
      end
      S_CMP_WT: begin
        state_next = S_CMP_CK;
      end
      S_CMP_CK: begin
        if (stat.cmp_eq) begin
          cmd.cmp_step = 1'b1;
          state_next   = S_CMP_RD;
        end else if (stat.probe_done) begin
          state_next = S_MISS;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_RD;
        end
      end
      S_MISS: begin
        cmd.ld_res = 1'b1;
        cmd.drop   = 1'b1;
        state_next = S_IDLE;
        if (!intern_op) begin
          cmd.res_status = ST_NOT_FOUND;
        end else if (!stat.slot_empty || !stat.tbl_cap) begin
          cmd.res_status = ST_TABLE_FULL;
        end else if (!stat.store_fit) begin
          cmd.res_status = ST_STORE_FULL;
        end else begin
          cmd.res_status = ST_NEW;
          cmd.res_slot   = 1'b1;
          cmd.commit     = 1'b1;
        end
      end
      S_LK_RD: begin
        cmd.rd_slot = 1'b1;
        state_next  = S_LK_CHK;
      end
      S_LK_CHK: begin
        if (stat.slot_id_eq) begin
          cmd.ld_res     = 1'b1;
          cmd.res_status = ST_FOUND;
          cmd.res_slot   = 1'b1;
          state_next     = S_IDLE;
        end else if (stat.probe_done) begin
          cmd.ld_res     = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_next     = S_IDLE;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_LK_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/sit_datapath.sv
// table, byte store, counters and result register
module sit_datapath
  import sit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sit_in_t    in_word,
  input  logic [7:0] max_entries,
  input  sit_cmd_t   cmd,
  output sit_stat_t  stat,
  output logic       out_valid,
  input  logic       out_ready,
  output sit_out_t   out_word
);

  localparam int TW = $clog2(TABLE_SLOTS);
  localparam int SW = $clog2(STORE_BYTES);
  localparam int FW = SW + 1;

  // slot memories; ids have valid bits so clear is immediate
  logic [31:0]       slot_hash [TABLE_SLOTS];
  logic [7:0]        slot_id_m [TABLE_SLOTS];
  logic [11:0]       slot_offset [TABLE_SLOTS];
  logic [11:0]       slot_length [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] slot_vld;
  logic [7:0]        byte_store [STORE_BYTES];

  logic [7:0]    entries_used;
  logic [FW-1:0] store_fill;
  logic [31:0]   requests_seen;
  logic [31:0]   dedup_seen;
  logic [31:0]   key_hash_acc;
  logic [FW-1:0] key_len_acc;
  logic          key_overflow;
  logic [7:0]    lk_id;

  logic [TW-1:0] probe_idx;
  logic [FW-1:0] probe_cnt;
  logic          rd_vld;
  logic [31:0]   rd_hash;
  logic [7:0]    rd_id;
  logic [11:0]   rd_off;
  logic [11:0]   rd_len;
  logic [FW-1:0] cmp_i;
  logic [7:0]    byte_a;
  logic [7:0]    byte_b;
  logic          cmp_oob;
  logic          oob_seen;

  logic [FW-1:0] stage_pos;
  logic [FW:0]   pos_a;
  logic [FW:0]   pos_b;
  logic [FW:0]   need;

  assign stage_pos = store_fill + key_len_acc;
  assign pos_a     = {{(FW+1-12){1'b0}}, rd_off} + {1'b0, cmp_i};
  assign pos_b     = {1'b0, store_fill} + {1'b0, cmp_i};
  assign need      = {1'b0, store_fill} + {1'b0, key_len_acc} + (FW+1)'(1);

  // key staging and counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      entries_used  <= '0;
      store_fill    <= '0;
      requests_seen <= '0;
      dedup_seen    <= '0;
      key_hash_acc  <= HASH_BASIS;
      key_len_acc   <= '0;
      key_overflow  <= 1'b0;
    end else begin
      if (cmd.stage) begin
        key_hash_acc <= (key_hash_acc ^ {24'd0, in_word.key_byte}) * HASH_PRIME;
        if (!key_overflow) begin
          if (stage_pos < FW'(STORE_BYTES)) begin
            key_len_acc <= key_len_acc + FW'(1);
          end else begin
            key_overflow <= 1'b1;
          end
        end
      end
      if (cmd.count_req) requests_seen <= requests_seen + 32'd1;
      if (cmd.count_dup) dedup_seen <= dedup_seen + 32'd1;
      if (cmd.commit) begin
        store_fill   <= need[FW-1:0];
        entries_used <= entries_used + 8'd1;
      end
      if (cmd.drop) begin
        key_hash_acc <= HASH_BASIS;
        key_len_acc  <= '0;
        key_overflow <= 1'b0;
      end
    end
  end

  // byte store write and read
  always_ff @(posedge clk) begin
    if (cmd.stage && !key_overflow && stage_pos < FW'(STORE_BYTES)) begin
      byte_store[stage_pos[SW-1:0]] <= in_word.key_byte;
    end else if (cmd.commit) begin
      byte_store[stage_pos[SW-1:0]] <= 8'd0;
    end
    if (cmd.rd_bytes) begin
      byte_a <= byte_store[pos_a[SW-1:0]];
      byte_b <= byte_store[pos_b[SW-1:0]];
    end
  end

  // slot valid bits
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      slot_vld <= '0;
    end else if (cmd.commit) begin
      slot_vld[probe_idx] <= 1'b1;
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_hash[probe_idx]   <= key_hash_acc;
      slot_id_m[probe_idx]   <= entries_used + 8'd1;
      slot_offset[probe_idx] <= store_fill[11:0];
      slot_length[probe_idx] <= key_len_acc[11:0];
    end
    if (cmd.rd_slot) begin
      rd_vld  <= slot_vld[probe_idx];
      rd_hash <= slot_hash[probe_idx];
      rd_id   <= slot_id_m[probe_idx];
      rd_off  <= slot_offset[probe_idx];
      rd_len  <= slot_length[probe_idx];
    end
  end

  // probe index, count and byte compare index
  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      probe_idx <= cmd.probe_lkp ? '0 : key_hash_acc[TW-1:0];
      probe_cnt <= FW'(1);
    end else if (cmd.probe_next) begin
      probe_idx <= probe_idx + TW'(1);
      probe_cnt <= probe_cnt + FW'(1);
    end
    if (cmd.probe_init && cmd.probe_lkp) lk_id <= in_word.string_id;
    if (cmd.cmp_init) begin
      cmp_i <= '0;
    end else if (cmd.cmp_step) begin
      cmp_i <= cmp_i + FW'(1);
    end
  end

  assign cmp_oob = (pos_a >= (FW+1)'(STORE_BYTES)) || (pos_b >= (FW+1)'(STORE_BYTES));

  // out-of-range compare reads as mismatch
  always_ff @(posedge clk) begin
    if (cmd.rd_bytes) oob_seen <= cmp_oob;
  end

  // status to controller
  always_comb begin
    stat.overflow     = key_overflow;
    stat.slot_empty   = !rd_vld;
    stat.slot_meta_eq = (rd_hash == key_hash_acc) && ({{(FW-12){1'b0}}, rd_len} == key_len_acc);
    stat.slot_id_eq   = rd_vld && (rd_id == lk_id);
    stat.probe_done   = (probe_cnt == FW'(TABLE_SLOTS));
    stat.cmp_done     = (cmp_i == key_len_acc);
    stat.cmp_eq       = (byte_a == byte_b) && !oob_seen;
    stat.tbl_cap      = (entries_used < max_entries);
    stat.store_fit    = (need <= (FW+1)'(STORE_BYTES));
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_res) begin
      out_word.status        <= cmd.res_status;
      out_word.result_id     <= !cmd.res_slot ? 8'd0 :
                                cmd.commit ? entries_used + 8'd1 : rd_id;
      out_word.store_offset  <= !cmd.res_slot ? 12'd0 :
                                cmd.commit ? store_fill[11:0] : rd_off;
      out_word.string_length <= !cmd.res_slot ? 12'd0 :
                                cmd.commit ? key_len_acc[11:0] : rd_len;
      out_word.entry_total   <= entries_used + {7'd0, cmd.commit};
      out_word.request_count <= requests_seen;
      out_word.dedup_count   <= dedup_seen + {31'd0, cmd.count_dup};
    end
  end

endmodule

### rtl/string_intern_table.sv
// string intern table: hashes keys byte by byte, probes linearly, returns ids
// a key byte is taken when idle and no result is stalled; a last byte then goes
// through start, slot read and slot check states and, per compared byte, read,
// wait and check states; lookup by id walks slots from zero, reading then checking each slot;
// one item at a time; a result waits in the output register
// reset is synchronous: slots empty, counters zero, max_entries 179
module string_intern_table
  import sit_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         cfg_we,
  input logic [7:0]   cfg_wdata,
  sit_stream_if.sink   in_ch,
  sit_stream_if.source out_ch
);

`include "string_intern_table_macros.svh"

  logic      [7:0] max_entries;
  sit_cmd_t  cmd;
  sit_stat_t stat;
  sit_in_t   in_word;
  sit_out_t  out_word;
  logic      out_valid;

  assign in_word = in_ch.data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= 8'd179;
    end else if (cfg_we) begin
      max_entries <= cfg_wdata;
    end
  end

  sit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_word  (in_word),
    .out_busy (out_valid && !out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sit_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_word     (in_word),
    .max_entries (max_entries),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ch.ready),
    .out_word    (out_word)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

  // checks
  `SIT_ASSERT_IMP(a_commit_new, clk, rst, cmd.commit, cmd.res_status == ST_NEW)
  `SIT_ASSERT_NEXT(a_ld_valid, clk, rst, cmd.ld_res, out_valid)
  `SIT_ASSERT_IMP(a_no_ld_busy, clk, rst, out_valid && !out_ch.ready, !cmd.ld_res)

endmodule

### verif/string_intern_table_tb.sv
// self-checking testbench for the string intern table, with its own predictor
module string_intern_table_tb;
  import sit_pkg::*;

  localparam int SLOTS = 256;
  localparam int STORE = 4096;
  localparam int SETTLE = 2000;

  typedef enum int {DO_WORD, DO_CFG, DO_DRAIN, DO_MODE} plan_kind_t;
  typedef struct {
    plan_kind_t kind;
    sit_in_t    word;
    logic [7:0] cfg;
    int         mode;
  } plan_t;
  typedef bit [7:0] key_t[$];

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  sit_stream_if #(.W($bits(sit_in_t)))  in_ch ();
  sit_stream_if #(.W($bits(sit_out_t))) out_ch ();

  string_intern_table uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // clock and reset
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // predicted table contents
  bit [31:0] tbl_hash[SLOTS];
  bit [7:0]  tbl_id[SLOTS];
  bit [11:0] tbl_off[SLOTS];
  bit [12:0] tbl_len[SLOTS];
  bit [7:0]  bytes_mem[STORE];
  int unsigned used_n, fill_n, key_len, entry_cap;
  bit [31:0] req_n, dup_n, key_hash;
  bit        key_ovf;

  sit_out_t  answers_due[$];
  plan_t     plan[$];
  int        errors = 0;
  int        send_idle = 7, recv_idle = 51;
  int        quiet_cycles = 0;

  function automatic void drop_staged();
    key_hash = HASH_BASIS;
    key_len = 0;
    key_ovf = 1'b0;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < SLOTS; i++) tbl_id[i] = 8'd0;
    used_n = 0;
    fill_n = 0;
    req_n = 0;
    dup_n = 0;
    drop_staged();
  endfunction

  function automatic void queue_answer(logic [2:0] st, logic [7:0] id, int slot, bit has_slot);
    sit_out_t r;
    r.status = st;
    r.result_id = id;
    r.store_offset = has_slot ? tbl_off[slot] : 12'd0;
    r.string_length = has_slot ? tbl_len[slot][11:0] : 12'd0;
    r.entry_total = used_n[7:0];
    r.request_count = req_n;
    r.dedup_count = dup_n;
    answers_due.push_back(r);
  endfunction

  function automatic bit staged_matches(int s);
    if (tbl_hash[s] != key_hash || tbl_len[s] != key_len) return 1'b0;
    for (int i = 0; i < key_len; i++) begin
      if (tbl_off[s] + i >= STORE || fill_n + i >= STORE) return 1'b0;
      if (bytes_mem[tbl_off[s] + i] != bytes_mem[fill_n + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected answer for one accepted word
  function automatic void intern_predict(sit_in_t w);
    int idx;
    int empty_slot;
    bit have_empty;
    bit is_intern;
    have_empty = 1'b0;
    empty_slot = 0;
    is_intern = (w.opcode == OP_INTERN);
    if (w.opcode == OP_CLEAR) begin
      wipe_table();
      return;
    end
    if (w.opcode == OP_LOOKUP) begin
      if (w.string_id == 8'd0) begin
        queue_answer(ST_NULL, 8'd0, 0, 1'b0);
        return;
      end
      for (int i = 0; i < SLOTS; i++)
        if (tbl_id[i] == w.string_id) begin
          queue_answer(ST_FOUND, w.string_id, i, 1'b1);
          return;
        end
      queue_answer(ST_NOT_FOUND, 8'd0, 0, 1'b0);
      return;
    end
    // stage the byte
    key_hash = (key_hash ^ {24'd0, w.key_byte}) * HASH_PRIME;
    if (!key_ovf) begin
      if (fill_n + key_len < STORE) begin
        bytes_mem[fill_n + key_len] = w.key_byte;
        key_len++;
      end else begin
        key_ovf = 1'b1;
      end
    end
    if (!w.key_last) return;
    if (is_intern) req_n++;
    if (key_ovf) begin
      drop_staged();
      queue_answer(ST_STORE_FULL, 8'd0, 0, 1'b0);
      return;
    end
    // linear probe from the low hash bits
    idx = key_hash[7:0];
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_id[idx] == 8'd0) begin
        have_empty = 1'b1;
        empty_slot = idx;
        break;
      end
      if (staged_matches(idx)) begin
        if (is_intern) dup_n++;
        drop_staged();
        queue_answer(ST_FOUND, tbl_id[idx], idx, 1'b1);
        return;
      end
      idx = (idx + 1) % SLOTS;
    end
    if (!is_intern) begin
      drop_staged();
      queue_answer(ST_NOT_FOUND, 8'd0, 0, 1'b0);
    end else if (!have_empty || used_n >= entry_cap) begin
      drop_staged();
      queue_answer(ST_TABLE_FULL, 8'd0, 0, 1'b0);
    end else if (fill_n + key_len + 1 > STORE) begin
      drop_staged();
      queue_answer(ST_STORE_FULL, 8'd0, 0, 1'b0);
    end else begin
      // commit the string and its terminator
      bytes_mem[fill_n + key_len] = 8'd0;
      tbl_hash[empty_slot] = key_hash;
      tbl_id[empty_slot] = 8'(used_n + 1);
      tbl_off[empty_slot] = 12'(fill_n);
      tbl_len[empty_slot] = 13'(key_len);
      fill_n += key_len + 1;
      used_n++;
      drop_staged();
      queue_answer(ST_NEW, tbl_id[empty_slot], empty_slot, 1'b1);
    end
  endfunction

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_hash[i] = 0;
      tbl_off[i] = 0;
      tbl_len[i] = 0;
    end
    entry_cap = 179;
    wipe_table();
  end

  // driver: feeds words from the plan, config writes only when drained
  always @(posedge clk) begin
    bit nxt_valid;
    sit_in_t w;
    nxt_valid = in_ch.valid;
    w = in_ch.data;
    if (rst) begin
      in_ch.valid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      cfg_we <= 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        intern_predict(in_ch.data);
        nxt_valid = 1'b0;
      end
      if (answers_due.size() == 0 && !in_ch.valid) quiet_cycles++;
      else quiet_cycles = 0;
      // control entries ahead of the next word
      while (!nxt_valid && plan.size() > 0 && plan[0].kind == DO_MODE) begin
        case (plan[0].mode)
          0: begin send_idle = 7; recv_idle = 51; end
          1: begin send_idle = 51; recv_idle = 7; end
          default: begin send_idle = 0; recv_idle = 0; end
        endcase
        void'(plan.pop_front());
      end
      if (!nxt_valid && plan.size() > 0) begin
        if (plan[0].kind == DO_WORD) begin
          if ($urandom_range(99) >= send_idle) begin
            w = plan.pop_front().word;
            nxt_valid = 1'b1;
          end
        end else if (!in_ch.valid && quiet_cycles >= SETTLE) begin
          if (plan[0].kind == DO_CFG) begin
            cfg_we <= 1'b1;
            cfg_wdata <= plan[0].cfg;
            entry_cap = plan[0].cfg;
          end
          void'(plan.pop_front());
          quiet_cycles = 0;
        end
      end
      in_ch.valid <= nxt_valid;
      in_ch.data <= w;
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // monitor: compares each answer word with the oldest expectation
  always @(posedge clk) begin
    sit_out_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (answers_due.size() == 0) begin
          report("unexpected word status", got.status, -1);
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.result_id !== want.result_id)
            report("result_id", got.result_id, want.result_id);
          if (got.store_offset !== want.store_offset)
            report("store_offset", got.store_offset, want.store_offset);
          if (got.string_length !== want.string_length)
            report("string_length", got.string_length, want.string_length);
          if (got.entry_total !== want.entry_total)
            report("entry_total", got.entry_total, want.entry_total);
          if (got.request_count !== want.request_count)
            report("request_count", got.request_count, want.request_count);
          if (got.dedup_count !== want.dedup_count)
            report("dedup_count", got.dedup_count, want.dedup_count);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // plan building helpers
  int words_planned = 0;

  task automatic add_word(logic [1:0] op, logic [7:0] b, logic l, logic [7:0] id);
    plan_t p;
    p.kind = DO_WORD;
    p.word.opcode = op;
    p.word.key_byte = b;
    p.word.key_last = l;
    p.word.string_id = id;
    p.cfg = 0;
    p.mode = 0;
    plan.push_back(p);
    words_planned++;
  endtask

  task automatic add_ctrl(plan_kind_t k, logic [7:0] v, int m);
    plan_t p;
    p.kind = k;
    p.word = '0;
    p.cfg = v;
    p.mode = m;
    plan.push_back(p);
  endtask

  task automatic add_key(logic [1:0] op, key_t k);
    for (int i = 0; i < k.size(); i++)
      add_word(op, k[i], i == k.size() - 1, 8'($urandom));
  endtask

  function automatic key_t random_key(int max_len);
    key_t k;
    int n;
    bit narrow;
    n = $urandom_range(max_len, 1);
    narrow = 1'($urandom_range(1));
    for (int i = 0; i < n; i++)
      k.push_back(narrow ? 8'($urandom_range(8'h64, 8'h61)) : 8'($urandom));
    return k;
  endfunction

  // stimulus and end of run
  initial begin
    key_t pool[32];
    int r;
    logic [7:0] caps[7] = '{8'd0, 8'd1, 8'd255, 8'd179, 8'd5, 8'd255, 8'd40};

    // directed: basic operations and edge values
    add_ctrl(DO_MODE, 0, 0);
    add_ctrl(DO_CFG, 8'd179, 0);
    add_key(OP_INTERN, '{8'h61});
    add_key(OP_INTERN, '{8'h61});
    add_key(OP_FIND, '{8'h61});
    add_key(OP_FIND, '{8'h62});
    add_word(OP_LOOKUP, 8'h00, 1'b0, 8'd0);
    add_word(OP_LOOKUP, 8'hff, 1'b1, 8'd1);
    add_word(OP_LOOKUP, 8'h00, 1'b0, 8'd255);
    add_key(OP_INTERN, '{8'h00, 8'hff});
    add_key(OP_INTERN, '{8'hff});
    // lookup and opcode change in the middle of a key
    add_word(OP_INTERN, 8'h78, 1'b0, 8'd0);
    add_word(OP_LOOKUP, 8'h00, 1'b0, 8'd2);
    add_word(OP_FIND, 8'h79, 1'b0, 8'd0);
    add_word(OP_INTERN, 8'h7a, 1'b1, 8'd0);
    add_word(OP_CLEAR, 8'h00, 1'b0, 8'd0);
    add_word(OP_LOOKUP, 8'h00, 1'b0, 8'd1);
    // zero capacity: every new intern is refused
    add_ctrl(DO_CFG, 8'd0, 0);
    add_key(OP_INTERN, '{8'h51, 8'h52});
    add_ctrl(DO_CFG, 8'd179, 0);

    // repeated, extended and changed keys after a clear
    add_word(OP_CLEAR, 8'h00, 1'b0, 8'd0);
    add_key(OP_INTERN, '{8'h61, 8'h62, 8'h63});
    add_key(OP_INTERN, '{8'h61, 8'h62, 8'h63});
    add_key(OP_FIND, '{8'h61, 8'h62, 8'h64});
    add_key(OP_INTERN, '{8'h61, 8'h62, 8'h64});
    add_key(OP_INTERN, '{8'h61, 8'h62, 8'h63, 8'h64});
    add_key(OP_FIND, '{8'h61, 8'h62, 8'h63, 8'h64, 8'h65});
    add_word(OP_LOOKUP, 8'h00, 1'b1, 8'd2);
    add_word(OP_CLEAR, 8'h00, 1'b0, 8'd0);

    // random part in three idling modes
    for (int i = 0; i < 32; i++) pool[i] = random_key(6);
    words_planned = 0;
    for (int m = 0; m < 3; m++) begin
      add_ctrl(DO_MODE, 0, m);
      for (int c = 0; c < 3; c++) begin
        add_ctrl(DO_CFG, caps[(3 * m + c) % 7] ^ ((m == 2 && c == 2) ? 8'($urandom) : 8'd0), 0);
        while (words_planned < (m * 3 + c + 1) * 195) begin
          r = $urandom_range(99);
          if (r < 40) add_key(OP_INTERN, pool[$urandom_range(31)]);
          else if (r < 55) add_key(OP_FIND, pool[$urandom_range(31)]);
          else if (r < 70) add_key(OP_INTERN, random_key(12));
          else if (r < 82) add_word(OP_LOOKUP, 8'($urandom), 1'($urandom),
                                    $urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom));
          else if (r < 84) add_word(OP_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom));
          else if (r < 90) add_key(OP_INTERN, random_key(60));
          else if (r < 95) begin
            // broken key: stray bytes with a lookup in between, then a mixed key
            add_word(2'($urandom_range(1)), 8'($urandom), 1'b0, 8'($urandom));
            add_word(OP_LOOKUP, 8'($urandom), 1'b0, 8'($urandom_range(20)));
            add_word(2'($urandom_range(1)), 8'($urandom), 1'b1, 8'($urandom));
          end else begin
            // pause until everything is answered, then carry on
            add_ctrl(DO_DRAIN, 0, 0);
            add_key(OP_INTERN, pool[$urandom_range(31)]);
          end
        end
        add_ctrl(DO_DRAIN, 0, 0);
      end
    end

    @(negedge rst);
    while (plan.size() > 0 || in_ch.valid || answers_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("string_intern_table_tb: PASS");
    end else begin
      $display("string_intern_table_tb: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("string_intern_table_tb: FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_stream_if.sv
rtl/sit_ctrl.sv
rtl/sit_datapath.sv
rtl/string_intern_table.sv
verif/string_intern_table_tb.sv
